// ===== rtl/facd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facd_pkg
// Shared constants, codes and types of the framed ascii command decoder.
// ----------------------------------------------------------------------------
package facd_pkg;

  localparam int CMD_CAPACITY = 16;
  localparam int COUNT_W      = $clog2(CMD_CAPACITY + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] SPEED_LIMIT_RESET = 16'd60000;

  localparam logic [7:0] CH_START = 8'd58;
  localparam logic [7:0] CH_END   = 8'd13;
  localparam logic [7:0] CH_QUERY = 8'd63;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_POS   = 8'h78;
  localparam logic [7:0] CH_SPD   = 8'h76;
  localparam logic [7:0] CH_ENA   = 8'h65;
  localparam logic [7:0] CH_EXM   = 8'h64;

  localparam logic [3:0] EV_SET_POS = 4'd0;
  localparam logic [3:0] EV_QRY_POS = 4'd1;
  localparam logic [3:0] EV_SET_SPD = 4'd2;
  localparam logic [3:0] EV_QRY_SPD = 4'd3;
  localparam logic [3:0] EV_ENABLE  = 4'd4;
  localparam logic [3:0] EV_EXAMPLE = 4'd5;
  localparam logic [3:0] EV_UNKNOWN = 4'd6;
  localparam logic [3:0] EV_SPD_IGN = 4'd7;
  localparam logic [3:0] EV_FULL    = 4'd8;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_FIRST  = 3'd1;
  localparam logic [2:0] OP_NEXT   = 3'd2;
  localparam logic [2:0] OP_DECODE = 3'd3;
  localparam logic [2:0] OP_FULL   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       second;
    logic [7:0] data;
  } facd_op_t;

endpackage : facd_pkg
`default_nettype wire

// ===== rtl/framed_ascii_command_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_ascii_command_decoder_unit
// Decodes ':'-framed ascii commands from a received byte stream.
//
// Input channel in_valid/in_ready carries one byte per beat on rx_byte.
// Output channel out_valid/out_ready carries one event per beat on
// event_kind and command_value; a carriage return closing a frame or a
// byte beyond the buffer capacity gives an event, other bytes give none.
// The front tracks framing and fill level and posts at most one operation
// per byte to a four-entry queue; the back accumulates arguments and decodes.
// One byte per cycle is sustained while the queue has room. An event is
// written to a queue entry and then to the result register.
// While a shown event waits on low out_ready the result register holds it,
// the back stops draining the queue and in_ready falls once the four queue
// entries fill. Reset empties the queue, drops any result, closes the frame
// and sets the speed limit to 60000. cfg_wr_en writes it from cfg_wr_data.
// ----------------------------------------------------------------------------
module framed_ascii_command_decoder_unit import facd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_kind,
  output logic [15:0]      command_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic     push;
  facd_op_t push_entry;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  facd_op_t q_head;

  facd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  facd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  facd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .command_value (command_value)
  );

endmodule : framed_ascii_command_decoder_unit
`default_nettype wire

// ===== rtl/facd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facd_front
// Accepts received bytes, tracks framing and fill level, classifies each beat.
// ----------------------------------------------------------------------------
module facd_front import facd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            push,
  output facd_op_t        push_entry
);

  logic               frame_active;
  logic               frame_active_next;
  logic [COUNT_W-1:0] stored_count;
  logic [COUNT_W-1:0] stored_count_next;
  logic               has_op;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_op;

  always_comb begin
    frame_active_next = frame_active;
    stored_count_next = stored_count;
    has_op            = 1'b1;
    push_entry.op     = OP_FULL;
    push_entry.second = (stored_count == COUNT_W'(1));
    push_entry.data   = rx_byte;
    priority if (rx_byte == CH_START) begin
      push_entry.op     = OP_CLEAR;
      frame_active_next = 1'b1;
      stored_count_next = '0;
    end else if (rx_byte == CH_END) begin
      push_entry.op     = OP_DECODE;
      has_op            = frame_active;
      frame_active_next = 1'b0;
    end else if (stored_count < COUNT_W'(CMD_CAPACITY)) begin
      push_entry.op     = (stored_count == '0) ? OP_FIRST : OP_NEXT;
      stored_count_next = stored_count + COUNT_W'(1);
    end else begin
      push_entry.op = OP_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      stored_count <= '0;
    end else if (accept) begin
      frame_active <= frame_active_next;
      stored_count <= stored_count_next;
    end
  end

endmodule : facd_front
`default_nettype wire

// ===== rtl/facd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facd_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module facd_fifo import facd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire facd_op_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output facd_op_t      head
);

  facd_op_t              mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_pop;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule : facd_fifo
`default_nettype wire

// ===== rtl/facd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facd_back
// Executes queued operations: argument accumulation, decode, result register.
// ----------------------------------------------------------------------------
module facd_back import facd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        q_not_empty,
  input  wire facd_op_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_kind,
  output logic [15:0]      command_value
);

  logic [15:0] speed_limit;
  logic [7:0]  opcode_char;
  logic        query_mark;
  logic [15:0] number_value;
  logic        number_stopped;
  logic [15:0] number_next;
  logic [7:0]  folded;
  logic [3:0]  dec_kind;
  logic [15:0] dec_value;
  logic        take;
  logic        emit;

  assign take  = q_not_empty && (!out_valid || out_ready);
  assign q_pop = take;
  assign emit  = take && (q_head.op == OP_DECODE || q_head.op == OP_FULL);

  // value * 10 + byte - '0', wrapping at 16 bits
  assign number_next = {number_value[12:0], 3'b000} + {number_value[14:0], 1'b0}
                     + {8'd0, q_head.data} - {8'd0, CH_ZERO};

  assign folded = opcode_char | CASE_BIT;

  always_comb begin
    dec_kind  = EV_UNKNOWN;
    dec_value = '0;
    if (opcode_char == (folded & ~CASE_BIT) || opcode_char == folded) begin
      unique case (folded)
        CH_POS: begin
          dec_kind  = query_mark ? EV_QRY_POS : EV_SET_POS;
          dec_value = query_mark ? 16'd0 : number_value;
        end
        CH_SPD: begin
          if (query_mark) begin
            dec_kind = EV_QRY_SPD;
          end else begin
            dec_value = number_value;
            dec_kind  = (number_value < speed_limit) ? EV_SET_SPD : EV_SPD_IGN;
          end
        end
        CH_ENA: begin
          dec_kind  = EV_ENABLE;
          dec_value = number_value;
        end
        CH_EXM: begin
          dec_kind = EV_EXAMPLE;
        end
        default: begin
          dec_kind = EV_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= SPEED_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      speed_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_char    <= '0;
      query_mark     <= 1'b0;
      number_value   <= '0;
      number_stopped <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      if (take) begin
        unique case (q_head.op)
          OP_CLEAR: begin
            opcode_char    <= '0;
            query_mark     <= 1'b0;
            number_value   <= '0;
            number_stopped <= 1'b0;
          end
          OP_FIRST: begin
            opcode_char <= q_head.data;
          end
          OP_NEXT: begin
            if (q_head.second) begin
              query_mark <= (q_head.data == CH_QUERY);
            end
            if (!number_stopped) begin
              if (q_head.data == CH_NUL) begin
                number_stopped <= 1'b1;
              end else begin
                number_value <= number_next;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_head.op == OP_DECODE) begin
      event_kind    <= dec_kind;
      command_value <= dec_value;
    end else if (take && q_head.op == OP_FULL) begin
      event_kind    <= EV_FULL;
      command_value <= '0;
    end
  end

endmodule : facd_back
`default_nettype wire

// ===== rtl/facd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facd_checker
// Port-level checks of the framed ascii command decoder.
// ----------------------------------------------------------------------------
module facd_checker import facd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  rx_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  event_kind,
  input wire logic [15:0] command_value,
  input wire logic        cfg_wr_en,
  input wire logic [15:0] cfg_wr_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(command_value))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind <= EV_FULL)
    else $error("event kind out of range");

  // kinds without an argument carry zero
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_QRY_POS || event_kind == EV_QRY_SPD ||
                  event_kind == EV_EXAMPLE || event_kind == EV_UNKNOWN ||
                  event_kind == EV_FULL) |-> command_value == 16'd0)
    else $error("argument on a kind without one");

endmodule : facd_checker

bind framed_ascii_command_decoder_unit facd_checker u_facd_checker (.*);
`default_nettype wire

// ===== bench/facd_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facd_event_checker
// Watches the byte, event and speed limit ports of the command decoder,
// tracks the framing and argument state of every accepted byte, and compares
// each event beat field by field with the oldest event still awaited.
// ----------------------------------------------------------------------------
module facd_event_checker import facd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  event_kind,
  input  logic [15:0] command_value,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          events_outstanding
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
  } cmd_event_t;

  cmd_event_t  awaited_events [$];
  logic [15:0] speed_limit;
  logic        in_frame;
  int          fill_level;
  logic [7:0]  opcode;
  logic        is_query;
  logic [15:0] argument;
  logic        argument_done;

  initial begin
    fail_count = 0;
    events_outstanding = 0;
  end

  function automatic void clear_text();
    fill_level    = 0;
    opcode        = CH_NUL;
    is_query      = 1'b0;
    argument      = 16'd0;
    argument_done = 1'b0;
  endfunction

  function automatic cmd_event_t decode_command();
    cmd_event_t ev;
    ev.value = 16'd0;
    case (opcode | CASE_BIT)
      CH_POS: begin
        if (is_query) begin
          ev.kind = EV_QRY_POS;
        end else begin
          ev.kind  = EV_SET_POS;
          ev.value = argument;
        end
      end
      CH_SPD: begin
        if (is_query) begin
          ev.kind = EV_QRY_SPD;
        end else begin
          ev.kind  = (argument < speed_limit) ? EV_SET_SPD : EV_SPD_IGN;
          ev.value = argument;
        end
      end
      CH_ENA: begin
        ev.kind  = EV_ENABLE;
        ev.value = argument;
      end
      CH_EXM:  ev.kind = EV_EXAMPLE;
      default: ev.kind = EV_UNKNOWN;
    endcase
    return ev;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    cmd_event_t ev;
    if (b == CH_START) begin
      clear_text();
      in_frame = 1'b1;
    end else if (b == CH_END) begin
      if (in_frame) begin
        awaited_events.push_back(decode_command());
        in_frame = 1'b0;
      end
    end else if (fill_level < CMD_CAPACITY) begin
      if (fill_level == 0) begin
        opcode = b;
      end else begin
        if (fill_level == 1)
          is_query = (b == CH_QUERY);
        if (!argument_done) begin
          if (b == CH_NUL)
            argument_done = 1'b1;
          else
            argument = argument * 16'd10 + 16'(b) - 16'(CH_ZERO);
        end
      end
      fill_level++;
    end else begin
      ev.kind  = EV_FULL;
      ev.value = 16'd0;
      awaited_events.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin : watch
    cmd_event_t seen;
    cmd_event_t want;
    if (rst) begin
      speed_limit = SPEED_LIMIT_RESET;
      in_frame    = 1'b0;
      clear_text();
      awaited_events.delete();
    end else begin
      if (cfg_wr_en)
        speed_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        seen.kind  = event_kind;
        seen.value = command_value;
        if (awaited_events.size() == 0) begin
          $error("unexpected event beat: event_kind %0d command_value %0d",
                 seen.kind, seen.value);
          fail_count++;
        end else begin
          want = awaited_events.pop_front();
          if (seen.kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, seen.kind);
            fail_count++;
          end
          if (seen.value !== want.value) begin
            $error("command_value: expected %0d, got %0d", want.value, seen.value);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        absorb_byte(rx_byte);
    end
    events_outstanding <= awaited_events.size();
  end

endmodule

// ===== bench/framed_ascii_command_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_ascii_command_decoder_unit_test
// Drives framed command text, broken frames, overflowing frames and raw
// noise into the decoder under several speed limits, with random gaps on
// the byte side and random stalls on the event side; the event checker
// beside the block predicts and compares every event beat.
// ----------------------------------------------------------------------------
module framed_ascii_command_decoder_unit_test;
  import facd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_kind;
  logic [15:0] command_value;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  int          fail_count;
  int          events_outstanding;
  int          bytes_sent = 0;
  logic        no_gaps = 1'b0;

  always #10 clk = ~clk;

  framed_ascii_command_decoder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .command_value (command_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  facd_event_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_kind         (event_kind),
    .command_value      (command_value),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .events_outstanding (events_outstanding)
  );

  function automatic int pick_pause(int long_low, int long_high);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(long_low, long_high);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_START || b == CH_END);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_pause(20, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic wait_events_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_speed_limit(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_number(input int unsigned v);
    int unsigned digit [5];
    int k;
    k = 0;
    do begin
      digit[k] = v % 10;
      v = v / 10;
      k++;
    end while (v > 0);
    for (int i = k - 1; i >= 0; i--)
      send_byte(CH_ZERO + 8'(digit[i]));
  endtask

  task automatic send_frame(input logic [15:0] limit);
    int pick;
    int n;
    logic [7:0] opc;
    logic [15:0] arg;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_byte(CH_START);
      case ($urandom_range(0, 9))
        0, 1:    opc = CH_POS;
        2, 3, 4: opc = CH_SPD;
        5, 6:    opc = CH_ENA;
        7:       opc = CH_EXM;
        default: opc = text_byte();
      endcase
      if ($urandom_range(0, 1) == 0)
        opc = opc & ~CASE_BIT;
      if ($urandom_range(0, 12) != 0)
        send_byte(opc);
      if ($urandom_range(0, 3) == 0)
        send_byte(CH_QUERY);
      if ($urandom_range(0, 7) == 0) begin
        // digit strings of up to nine digits, which can wrap the argument
        n = $urandom_range(0, 9);
        repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        case ($urandom_range(0, 5))
          0:       arg = limit - 16'd1;
          1:       arg = limit;
          2:       arg = limit + 16'd1;
          3:       arg = 16'($urandom_range(0, 65535));
          4:       arg = 16'($urandom_range(0, 99));
          default: arg = 16'hFFFF;
        endcase
        send_number(arg);
      end
      if ($urandom_range(0, 7) == 0)
        send_byte(text_byte());
      send_byte(CH_END);
    end else if (pick < 80) begin
      // frame running up to or past the buffer capacity
      send_byte(CH_START);
      n = $urandom_range(CMD_CAPACITY - 1, CMD_CAPACITY + 4);
      repeat (n) send_byte(text_byte());
      if ($urandom_range(0, 3) != 0)
        send_byte(CH_END);
    end else if (pick < 90) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // text with no frame open
      send_byte(CH_END);
      n = $urandom_range(0, CMD_CAPACITY + 4);
      repeat (n) send_byte(text_byte());
    end
  endtask

  initial begin : event_side_stalls
    int len;
    forever begin
      out_ready <= 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      repeat (len) @(posedge clk);
      len = pick_pause(30, 60);
      if (len > 0) begin
        out_ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL framed_ascii_command_decoder_unit");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] phase_limit [5];
    logic [15:0] limit;
    int target;

    phase_limit[0] = 16'd0;
    phase_limit[1] = 16'hFFFF;
    phase_limit[2] = 16'd1;
    phase_limit[3] = 16'($urandom_range(0, 65535));
    phase_limit[4] = 16'd300;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed opening under the reset limit
    send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_POS); send_byte(CH_QUERY); send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_SPD & ~CASE_BIT); send_byte(CH_ZERO + 8'd7);
    send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_ENA); send_byte(8'hFF); send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_EXM & ~CASE_BIT); send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_NUL); send_byte(CH_END);
    send_byte(CH_START); send_byte(CH_POS & ~CASE_BIT); send_byte(CH_ZERO + 8'd1);
    send_byte(CH_NUL); send_byte(CH_ZERO + 8'd9); send_byte(CH_END);

    limit  = SPEED_LIMIT_RESET;
    target = bytes_sent + 80;
    while (bytes_sent < target) send_frame(limit);
    wait_events_drained();

    for (int p = 0; p < 5; p++) begin
      limit = phase_limit[p];
      write_speed_limit(limit);
      no_gaps = ($urandom_range(0, 2) == 0);
      target  = bytes_sent + 85;
      while (bytes_sent < target) send_frame(limit);
      no_gaps = 1'b0;
      wait_events_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASS framed_ascii_command_decoder_unit");
    else
      $display("FAIL framed_ascii_command_decoder_unit");
    $finish;
  end

endmodule
